### rtl/core/vkv_pkg.sv
// ----------------------------------------------------------------------------
// Vehicle kinematics package
// Constants and the CORDIC angle table shared by the kinematics core.
// ----------------------------------------------------------------------------
`default_nettype none

package vkv_pkg;

  localparam int TABLE_LEN        = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD_BITS       = 12;
  localparam int RATE_W           = 10;
  localparam logic [RATE_W-1:0] RATE_RESET = 10'd10;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam int DEG180           = 11796480;
  localparam int HEADING_MAX      = 23040;
  localparam int ATAN_W           = 23;
  localparam int IDX_W            = $clog2(TABLE_LEN);

  // Angle of atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_deg16(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] a;
    begin
      case (idx)
        5'd0: a = 23'd2949120;
        5'd1: a = 23'd1740967;
        5'd2: a = 23'd919879;
        5'd3: a = 23'd466945;
        5'd4: a = 23'd234379;
        5'd5: a = 23'd117304;
        5'd6: a = 23'd58666;
        5'd7: a = 23'd29335;
        5'd8: a = 23'd14668;
        5'd9: a = 23'd7334;
        5'd10: a = 23'd3667;
        5'd11: a = 23'd1833;
        5'd12: a = 23'd917;
        5'd13: a = 23'd458;
        5'd14: a = 23'd229;
        5'd15: a = 23'd115;
        5'd16: a = 23'd57;
        5'd17: a = 23'd29;
        5'd18: a = 23'd14;
        5'd19: a = 23'd7;
        5'd20: a = 23'd4;
        5'd21: a = 23'd2;
        5'd22: a = 23'd1;
        default: a = 23'd0;
      endcase
      return a;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/vehicle_kinematics_from_velocity_core.sv
// ----------------------------------------------------------------------------
// Vehicle kinematics from velocity core
// Speed, heading and acceleration of two velocity vectors by one shared
// CORDIC vectoring datapath and one shared multiplier.
// ----------------------------------------------------------------------------
// Each vector passes through the load, rotation, multiply and scale states in
// turn; a vector with zero lateral part skips its rotations and is settled in
// the load state. The two accelerations and the output follow. A new item is
// taken only in idle, after the last one has left for the output register;
// a result still held in the output register stalls the next one.
// Reset clears the sequencer, the output valid, the previous speeds and sets
// the sample rate to 10 Hz.
`default_nettype none

module vehicle_kinematics_from_velocity_core
  import vkv_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic [RATE_W-1:0]        cfg_write_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [15:0]       ego_long_velocity,
  input  wire logic signed [15:0]       ego_lat_velocity,
  input  wire logic signed [15:0]       veh_long_velocity,
  input  wire logic signed [15:0]       veh_lat_velocity,
  input  wire logic                     first_sample,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [15:0]                   ego_speed,
  output logic signed [15:0]            ego_heading,
  output logic signed [26:0]            ego_accel,
  output logic [15:0]                   veh_speed,
  output logic signed [15:0]            veh_heading,
  output logic signed [26:0]            veh_accel,
  output logic signed [16:0]            rel_speed,
  output logic signed [27:0]            rel_accel
);

  localparam int STEPS     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [IDX_W-1:0] ITER_LAST = IDX_W'(STEPS - 1);
  localparam int XW        = 31;
  localparam int ZW        = 27;
  localparam int BW        = 33;
  localparam int PW        = XW + BW;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< 43;
  localparam logic signed [ZW-1:0] Z180 = ZW'(DEG180);
  localparam logic signed [ZW-1:0] HMAX = ZW'(HEADING_MAX);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ITER, S_MUL, S_SCALE, S_ACC_E, S_ACC_V, S_OUT
  } state_t;

  state_t state;
  logic   vsel;
  logic [IDX_W-1:0] iter;
  logic [RATE_W-1:0] sample_rate;

  logic signed [15:0] ego_lon_q, ego_lat_q, veh_lon_q, veh_lat_q;
  logic first_q;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic signed [PW-1:0] prod;
  logic [15:0] ego_spd, veh_spd;
  logic signed [15:0] ego_hd, veh_hd;
  logic signed [26:0] ego_acc, veh_acc;
  logic signed [16:0] prev_ego_speed, prev_veh_speed;

  logic signed [15:0] lon, lat;
  logic signed [XW-1:0] lon_s, lat_s, dx, dy, x_pos;
  logic signed [ZW-1:0] atan_z, z_rnd, hd_full;
  logic signed [16:0] lon_abs, spd_diff;
  logic [15:0] res_spd, zl_spd;
  logic signed [15:0] res_hd, zl_hd;
  logic signed [PW-1:0] prod_rnd, mul_p;
  logic signed [XW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  always_comb begin
    lon     = vsel ? veh_lon_q : ego_lon_q;
    lat     = vsel ? veh_lat_q : ego_lat_q;
    lon_s   = {{(XW-16-GUARD_BITS){lon[15]}}, lon, {GUARD_BITS{1'b0}}};
    lat_s   = {{(XW-16-GUARD_BITS){lat[15]}}, lat, {GUARD_BITS{1'b0}}};
    lon_abs = lon[15] ? -17'(lon) : 17'(lon);
    zl_spd  = lon_abs[15:0];
    zl_hd   = lon[15] ? 16'(HEADING_MAX) : 16'sd0;
    dx      = y >>> iter;
    dy      = x >>> iter;
    atan_z  = $signed(ZW'(atan_deg16(iter)));
    x_pos   = x[XW-1] ? '0 : x;
    spd_diff = (state == S_ACC_V) ? ($signed({1'b0, veh_spd}) - prev_veh_speed)
                                  : ($signed({1'b0, ego_spd}) - prev_ego_speed);
    if (state == S_MUL) begin
      mul_a = x_pos;
      mul_b = $signed({1'b0, INV_GAIN_Q32});
    end else begin
      mul_a = XW'(spd_diff);
      mul_b = $signed(BW'(sample_rate));
    end
    mul_p    = PW'(mul_a) * PW'(mul_b);
    prod_rnd = prod + RND;
    res_spd  = (|prod_rnd[PW-1:60]) ? 16'hFFFF : prod_rnd[59:44];
    z_rnd    = z + ZW'(256);
    hd_full  = z_rnd >>> 9;
    if (hd_full > HMAX) begin
      res_hd = 16'(HEADING_MAX);
    end else if (hd_full < -HMAX) begin
      res_hd = -16'(HEADING_MAX);
    end else begin
      res_hd = hd_full[15:0];
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      vsel           <= 1'b0;
      iter           <= '0;
      sample_rate    <= RATE_RESET;
      out_valid      <= 1'b0;
      prev_ego_speed <= '0;
      prev_veh_speed <= '0;
    end else begin
      if (cfg_write_en) begin
        sample_rate <= cfg_write_data;
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ego_lon_q <= ego_long_velocity;
            ego_lat_q <= ego_lat_velocity;
            veh_lon_q <= veh_long_velocity;
            veh_lat_q <= veh_lat_velocity;
            first_q   <= first_sample;
            vsel      <= 1'b0;
            state     <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (lat == 16'sd0) begin
            if (vsel) begin
              veh_spd <= zl_spd;
              veh_hd  <= zl_hd;
              state   <= S_ACC_E;
            end else begin
              ego_spd <= zl_spd;
              ego_hd  <= zl_hd;
              vsel    <= 1'b1;
            end
          end else begin
            iter <= '0;
            if (lon[15]) begin
              x <= -lon_s;
              y <= -lat_s;
              z <= lat[15] ? -Z180 : Z180;
            end else begin
              x <= lon_s;
              y <= lat_s;
              z <= '0;
            end
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (y[XW-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_z;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_z;
          end
          iter <= iter + IDX_W'(1);
          if (iter == ITER_LAST) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (vsel) begin
            veh_spd <= res_spd;
            veh_hd  <= res_hd;
            state   <= S_ACC_E;
          end else begin
            ego_spd <= res_spd;
            ego_hd  <= res_hd;
            vsel    <= 1'b1;
            state   <= S_LOAD;
          end
        end
        S_ACC_E: begin
          ego_acc <= first_q ? 27'sd0 : mul_p[26:0];
          state   <= S_ACC_V;
        end
        S_ACC_V: begin
          veh_acc <= first_q ? 27'sd0 : mul_p[26:0];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            ego_speed      <= ego_spd;
            ego_heading    <= ego_hd;
            ego_accel      <= ego_acc;
            veh_speed      <= veh_spd;
            veh_heading    <= veh_hd;
            veh_accel      <= veh_acc;
            rel_speed      <= $signed({1'b0, ego_spd}) - $signed({1'b0, veh_spd});
            rel_accel      <= 28'(ego_acc) - 28'(veh_acc);
            prev_ego_speed <= $signed({1'b0, ego_spd});
            prev_veh_speed <= $signed({1'b0, veh_spd});
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ITER |-> iter <= ITER_LAST)
    else $error("rotation counter ran past the last step");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ego_heading <= 16'sd23040) && (ego_heading >= -16'sd23040) &&
                  (veh_heading <= 16'sd23040) && (veh_heading >= -16'sd23040))
    else $error("heading outside the half-turn range");

  a_rel_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rel_speed == ($signed({1'b0, ego_speed}) - $signed({1'b0, veh_speed})))
    else $error("relative speed does not match the two speeds");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && first_q |-> ego_acc == 27'sd0 && veh_acc == 27'sd0)
    else $error("non-zero acceleration on the first item of a log");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vehicle kinematics core testbench
// Drives velocity samples through a valid/ready driver with random gaps and
// checks every result against an in-bench CORDIC predictor of speed, heading
// and acceleration. Phases run at several sample rates and include a long
// receiver stall.
// ----------------------------------------------------------------------------

module tb;
  import vkv_pkg::*;

  localparam int CORDIC_STEPS_TB = CORDIC_STEPS_DEF;
  localparam int PHASE_ITEMS = 180;
  localparam longint ROT_ANGLE [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [15:0] ego_long;
    logic [15:0] ego_lat;
    logic [15:0] veh_long;
    logic [15:0] veh_lat;
    logic        first;
  } velocity_sample_t;

  typedef struct packed {
    logic [15:0] ego_speed;
    logic [15:0] ego_heading;
    logic [26:0] ego_accel;
    logic [15:0] veh_speed;
    logic [15:0] veh_heading;
    logic [26:0] veh_accel;
    logic [16:0] rel_speed;
    logic [27:0] rel_accel;
  } kinematics_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [RATE_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] ego_long_velocity = '0;
  logic [15:0] ego_lat_velocity = '0;
  logic [15:0] veh_long_velocity = '0;
  logic [15:0] veh_lat_velocity = '0;
  logic first_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] ego_speed;
  logic signed [15:0] ego_heading;
  logic signed [26:0] ego_accel;
  logic [15:0] veh_speed;
  logic signed [15:0] veh_heading;
  logic signed [26:0] veh_accel;
  logic signed [16:0] rel_speed;
  logic signed [27:0] rel_accel;

  velocity_sample_t pending_samples[$];
  kinematics_t expected_kinematics[$];
  velocity_sample_t sample_on_bus;

  int rate_model = int'(RATE_RESET);
  longint prev_ego_speed = 0;
  longint prev_veh_speed = 0;

  bit quiet = 1'b0;
  bit rx_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_cycles = 0;
  int hold_results = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int mismatches = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int logs_started = 0;

  vehicle_kinematics_from_velocity_core #(
    .CORDIC_STEPS(CORDIC_STEPS_TB)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ego_long_velocity(ego_long_velocity),
    .ego_lat_velocity(ego_lat_velocity),
    .veh_long_velocity(veh_long_velocity),
    .veh_lat_velocity(veh_lat_velocity),
    .first_sample(first_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ego_speed(ego_speed),
    .ego_heading(ego_heading),
    .ego_accel(ego_accel),
    .veh_speed(veh_speed),
    .veh_heading(veh_heading),
    .veh_accel(veh_accel),
    .rel_speed(rel_speed),
    .rel_accel(rel_accel)
  );

  always #5 clk = ~clk;

  function automatic void polar_of(input logic [15:0] lon_bits, input logic [15:0] lat_bits,
                                   output logic [15:0] speed, output logic [15:0] heading);
    longint lon, lat, x, y, z, dx, dy, h;
    longint unsigned ux, mag;
    int n, i;
    lon = longint'($signed(lon_bits));
    lat = longint'($signed(lat_bits));
    if (lat == 0) begin
      speed = 16'(lon < 0 ? -lon : lon);
      heading = 16'(lon < 0 ? longint'(HEADING_MAX) : longint'(0));
      return;
    end
    x = lon <<< GUARD_BITS;
    y = lat <<< GUARD_BITS;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
      x = -x;
      y = -y;
    end
    n = (CORDIC_STEPS_TB > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS_TB;
    for (i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end
    end
    if (x < 0) x = 0;
    ux = x;
    mag = (ux * 64'(INV_GAIN_Q32) + (64'd1 << 43)) >> 44;
    if (mag > 65535) mag = 65535;
    speed = 16'(mag);
    h = (z + 256) >>> 9;
    if (h > HEADING_MAX) h = HEADING_MAX;
    if (h < -HEADING_MAX) h = -HEADING_MAX;
    heading = 16'(h);
  endfunction

  function automatic kinematics_t predict_kinematics(input velocity_sample_t s);
    kinematics_t r;
    logic [15:0] es_b, eh_b, vs_b, vh_b;
    longint es, vs, ea, va;
    polar_of(s.ego_long, s.ego_lat, es_b, eh_b);
    polar_of(s.veh_long, s.veh_lat, vs_b, vh_b);
    es = longint'(es_b);
    vs = longint'(vs_b);
    ea = s.first ? 0 : (es - prev_ego_speed) * rate_model;
    va = s.first ? 0 : (vs - prev_veh_speed) * rate_model;
    prev_ego_speed = es;
    prev_veh_speed = vs;
    r.ego_speed = es_b;
    r.ego_heading = eh_b;
    r.ego_accel = 27'(ea);
    r.veh_speed = vs_b;
    r.veh_heading = vh_b;
    r.veh_accel = 27'(va);
    r.rel_speed = 17'(es - vs);
    r.rel_accel = 28'(ea - va);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers pending items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_kinematics.push_back(predict_kinematics(sample_on_bus));
        items_accepted++;
      end
      if (in_valid && !in_ready) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0 && !quiet && !rx_hold &&
                   $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        sample_on_bus = pending_samples.pop_front();
        ego_long_velocity <= sample_on_bus.ego_long;
        ego_lat_velocity <= sample_on_bus.ego_lat;
        veh_long_velocity <= sample_on_bus.veh_long;
        veh_lat_velocity <= sample_on_bus.veh_lat;
        first_sample <= sample_on_bus.first;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result and throttles out_ready.
  always @(posedge clk) begin
    kinematics_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_kinematics.size() == 0) begin
          $error("Result received with no item outstanding");
          mismatches++;
        end else begin
          want = expected_kinematics.pop_front();
          check_field("ego_speed", 32'(want.ego_speed), 32'(ego_speed));
          check_field("ego_heading", 32'(want.ego_heading), 32'($unsigned(ego_heading)));
          check_field("ego_accel", 32'(want.ego_accel), 32'($unsigned(ego_accel)));
          check_field("veh_speed", 32'(want.veh_speed), 32'(veh_speed));
          check_field("veh_heading", 32'(want.veh_heading), 32'($unsigned(veh_heading)));
          check_field("veh_accel", 32'(want.veh_accel), 32'($unsigned(veh_accel)));
          check_field("rel_speed", 32'(want.rel_speed), 32'($unsigned(rel_speed)));
          check_field("rel_accel", 32'(want.rel_accel), 32'($unsigned(rel_accel)));
          results_checked++;
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One long receiver stall so that the core backs up onto its input.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) hold_results++;
      if (rx_hold) begin
        hold_cycles++;
        if (hold_cycles >= 600) begin
          rx_hold <= 1'b0;
          hold_done <= 1'b1;
        end
      end else if (!hold_done && hold_results >= 150) begin
        rx_hold <= 1'b1;
      end
    end
  end

  task automatic push_sample(input int el, input int et, input int vl, input int vt,
                             input bit first);
    velocity_sample_t s;
    s.ego_long = 16'(el);
    s.ego_lat = 16'(et);
    s.veh_long = 16'(vl);
    s.veh_lat = 16'(vt);
    s.first = first;
    pending_samples.push_back(s);
  endtask

  function automatic int walk(input int v);
    int n;
    n = v + int'($urandom_range(0, 1200)) - 600;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n;
  endfunction

  task automatic fill_random(input int target);
    int count, len, k, el, et, vl, vt;
    bit ego_flat, veh_flat;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_sample($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        count++;
      end else begin
        len = $urandom_range(3, 30);
        el = int'($signed(16'($urandom)));
        et = int'($signed(16'($urandom)));
        vl = int'($signed(16'($urandom)));
        vt = int'($signed(16'($urandom)));
        ego_flat = ($urandom_range(0, 7) == 0);
        veh_flat = ($urandom_range(0, 7) == 0);
        logs_started++;
        for (k = 0; k < len; k++) begin
          push_sample(el, ego_flat ? 0 : et, vl, veh_flat ? 0 : vt, k == 0);
          el = walk(el);
          et = walk(et);
          vl = walk(vl);
          vt = walk(vt);
          count++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_kinematics.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_sample_rate(input int rate);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= RATE_W'(rate);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    rate_model = rate;
    @(negedge clk);
  endtask

  initial begin
    int rates[6];
    int p;
    rates = '{0, 1, 1000, 1023, 0, 0};
    rates[4] = $urandom_range(2, 999);
    rates[5] = $urandom_range(2, 999);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_sample(0, 0, 0, 0, 1);
    push_sample(32767, 0, -32768, 0, 0);
    push_sample(-32768, 0, 32767, 0, 0);
    push_sample(0, 32767, 0, -32768, 0);
    push_sample(0, -32768, 0, 32767, 0);
    push_sample(32767, 32767, -32768, -32768, 0);
    push_sample(-32768, 32767, 32767, -32768, 0);
    push_sample(-32768, 1, -32768, -1, 0);
    push_sample(-1, 1, -1, -1, 0);
    push_sample(1, -1, 1, 1, 0);
    push_sample(-5, 0, 5, 0, 1);
    push_sample(256, 256, -256, 256, 0);
    push_sample(100, -300, -300, 100, 0);
    push_sample(0, 0, 32767, 32767, 0);
    push_sample(32767, 32767, 0, 0, 0);
    push_sample(-32768, -32768, -32768, -32768, 0);
    push_sample(1, 0, 0, 1, 0);
    push_sample(0, -1, -1, 0, 0);
    push_sample(12345, -6789, -23456, 4321, 1);
    push_sample(-32768, -1, -1, -32768, 0);
    push_sample(-32768, -32768, 32767, 32767, 0);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      set_sample_rate(rates[p]);
      if (p == 5) quiet = 1'b1;
      push_sample(-32768, -32768, 32767, 32767, 1);
      push_sample(32767, 32767, 0, 0, 0);
      push_sample(0, 0, -32768, -32768, 0);
      fill_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d results from %0d items (%0d logs plus noise and field extremes).",
             results_checked, items_accepted, logs_started);
    $display("Sample rates 10, 0, 1, 1000, 1023, %0d and %0d; one long output stall.",
             rates[4], rates[5]);
    if (mismatches == 0 && expected_kinematics.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", expected_kinematics.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
